// ===== src/esd_pkg.sv =====
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

	// Input and result transaction payloads
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} esd_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} esd_out_t;

	// Up to three decoded bytes produced by one input transaction
	localparam int unsigned MaxResults = 3;

	typedef struct packed {
		logic [1:0]                  cnt;
		logic [MaxResults-1:0][7:0]  bytes;
		logic                        last;
	} esd_bundle_t;

	// Character codes
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LC_N   = 8'h6e;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;

	// Control codes the single-character escapes map to
	localparam logic [7:0] CODE_LF = 8'h0a;
	localparam logic [7:0] CODE_CR = 8'h0d;
	localparam logic [7:0] CODE_HT = 8'h09;
	localparam logic [7:0] CODE_VT = 8'h0b;
	localparam logic [7:0] CODE_FF = 8'h0c;

	// Hex digit test: bit 4 flags a digit, bits 3:0 give its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = c - CH_ZERO;
			return {1'b1, d[3:0]};
		end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
			d = c - CH_LC_A + 8'd10;
			return {1'b1, d[3:0]};
		end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
			d = c - CH_UC_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return (c inside {[CH_ZERO:CH_SEVEN]});
	endfunction

endpackage

// ===== src/esd_decode.sv =====
// Input register, escape state and single-pass decode of one transaction.
module esd_decode import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  esd_in_t     in_item,
	input  logic        room,
	output logic        load,
	output esd_bundle_t bundle
);

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX   = 3'd2,
		MODE_OCT   = 3'd3
	} mode_t;

	logic        valid_s1;
	esd_in_t     item_s1;
	mode_t       mode_q;
	logic [7:0]  value_q;
	logic [1:0]  count_q;
	logic [7:0]  letter_q;

	mode_t       m;
	logic [7:0]  v;
	logic [1:0]  dc;
	logic [7:0]  l;
	logic [1:0]  n;
	logic [MaxResults-1:0][7:0] res;
	logic [4:0]  hd;
	logic [7:0]  c;
	logic        advance;

	assign c  = item_s1.in_byte;
	assign hd = hex_digit(c);

	// Decode one byte against the escape state
	always_comb begin
		m   = mode_q;
		v   = value_q;
		dc  = count_q;
		l   = letter_q;
		n   = 2'd0;
		res = '0;

		case (mode_q)
			MODE_ESC: begin
				case (c)
					CH_LC_N: begin res[n] = CODE_LF; n = n + 2'd1; end
					CH_LC_R: begin res[n] = CODE_CR; n = n + 2'd1; end
					CH_LC_T: begin res[n] = CODE_HT; n = n + 2'd1; end
					CH_LC_B: begin res[n] = CODE_VT; n = n + 2'd1; end
					CH_LC_F: begin res[n] = CODE_FF; n = n + 2'd1; end
					CH_BSLASH, CH_DOLLAR, CH_DQUOTE: begin
						res[n] = c; n = n + 2'd1;
					end
					CH_LC_X, CH_UC_X: begin
						m = MODE_HEX;
						l = c;
						v = 8'h00;
						dc = 2'd0;
					end
					default: begin
						if (is_octal(c)) begin
							m = MODE_OCT;
							v = {5'b0, c[2:0]};
							dc = 2'd1;
						end else begin
							res[n] = CH_BSLASH; n = n + 2'd1;
							res[n] = c;         n = n + 2'd1;
						end
					end
				endcase
				if (m == MODE_ESC) begin
					m = MODE_PLAIN; v = 8'h00; dc = 2'd0; l = 8'h00;
				end
			end
			MODE_HEX, MODE_OCT: begin
				if (mode_q == MODE_HEX && hd[4]) begin
					v = {v[3:0], hd[3:0]};
					dc = dc + 2'd1;
					if (dc == 2'd2) begin
						res[n] = v; n = n + 2'd1;
						m = MODE_PLAIN; v = 8'h00; dc = 2'd0; l = 8'h00;
					end
				end else if (mode_q == MODE_OCT && is_octal(c)) begin
					v = {v[4:0], c[2:0]};
					dc = dc + 2'd1;
					if (dc == 2'd3) begin
						res[n] = v; n = n + 2'd1;
						m = MODE_PLAIN; v = 8'h00; dc = 2'd0; l = 8'h00;
					end
				end else begin
					// Flush the pending escape, then treat the byte as plain text
					if (mode_q == MODE_HEX && dc == 2'd0) begin
						res[n] = CH_BSLASH; n = n + 2'd1;
						res[n] = l;         n = n + 2'd1;
					end else begin
						res[n] = v; n = n + 2'd1;
					end
					m = MODE_PLAIN; v = 8'h00; dc = 2'd0; l = 8'h00;
					if (c == CH_BSLASH) begin
						m = MODE_ESC;
					end else begin
						res[n] = c; n = n + 2'd1;
					end
				end
			end
			default: begin
				m = MODE_PLAIN;
				if (c == CH_BSLASH) begin
					m = MODE_ESC; v = 8'h00; dc = 2'd0;
				end else begin
					res[n] = c; n = n + 2'd1;
				end
			end
		endcase

		// Flush whatever is pending at the end of the string
		if (item_s1.in_last) begin
			case (m)
				MODE_ESC: begin
					res[n] = CH_BSLASH; n = n + 2'd1;
				end
				MODE_HEX: begin
					if (dc == 2'd0) begin
						res[n] = CH_BSLASH; n = n + 2'd1;
						res[n] = l;         n = n + 2'd1;
					end else begin
						res[n] = v; n = n + 2'd1;
					end
				end
				MODE_OCT: begin
					res[n] = v; n = n + 2'd1;
				end
				default: begin
				end
			endcase
			m = MODE_PLAIN; v = 8'h00; dc = 2'd0; l = 8'h00;
		end
	end

	// Advance when the result register can take the bundle, or nothing comes out
	assign advance  = valid_s1 && ((n == 2'd0) || room);
	assign load     = advance && (n != 2'd0);
	assign in_stall = valid_s1 && !advance;

	assign bundle.cnt   = n;
	assign bundle.bytes = res;
	assign bundle.last  = item_s1.in_last;

	// Hold the accepted transaction until it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Update escape state as each transaction is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			value_q  <= 8'h00;
			count_q  <= 2'd0;
			letter_q <= 8'h00;
		end else if (advance) begin
			mode_q   <= m;
			value_q  <= v;
			count_q  <= dc;
			letter_q <= l;
		end
	end

endmodule

// ===== src/esd_outq.sv =====
// Result register holding up to three decoded bytes, drained one per cycle unless stalled.
module esd_outq import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  esd_bundle_t bundle,
	output logic        room,
	output logic        out_valid,
	input  logic        out_stall,
	output esd_out_t    out_item
);

	logic [1:0]                 cnt_s2;
	logic [MaxResults-1:0][7:0] bytes_s2;
	logic                       last_s2;
	logic                       take;

	assign out_valid         = (cnt_s2 != 2'd0);
	assign take              = out_valid && !out_stall;
	assign room              = (cnt_s2 == 2'd0) || ((cnt_s2 == 2'd1) && !out_stall);
	assign out_item.out_byte = bytes_s2[0];
	assign out_item.out_last = last_s2 && (cnt_s2 == 2'd1);

	// Load a new bundle or shift out the delivered byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (load) begin
			cnt_s2 <= bundle.cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= bundle.bytes;
			last_s2  <= bundle.last;
		end else if (take) begin
			bytes_s2 <= {8'h00, bytes_s2[MaxResults-1:1]};
		end
	end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// Escape sequence decoder: a transaction passes the input register, is decoded, then
// is loaded into the result register. One input transaction is accepted per cycle while
// each yields at most one byte and out_stall is low; one yielding k bytes (k <= 3)
// holds the result register until the single-byte output port has drained all k.
// Reset (arst_n low, asynchronous) empties both registers and returns to plain text.
module escape_sequence_decoder import esd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  esd_in_t  in_item,
	output logic     out_valid,
	input  logic     out_stall,
	output esd_out_t out_item
);

	logic        room;
	logic        load;
	esd_bundle_t bundle;

	esd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.room     (room),
		.load     (load),
		.bundle   (bundle)
	);

	esd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== src/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
module esd_checker import esd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input esd_in_t  in_item,
	input logic     out_valid,
	input logic     out_stall,
	input esd_out_t out_item
);

	// A stalled result transaction stays valid and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result transaction changed");

	// Input only stalls behind pending results
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// A blocked input stays blocked while the output remains stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && in_stall ##1 out_stall |-> in_stall)
		else $error("input released while output stalled");

	// An offered result transaction carries known data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_item))
		else $error("result transaction has unknown bits");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the escape sequence decoder: directed and random strings.
module testbench import esd_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Decoder modes tracked by the predictor
	typedef enum logic [2:0] {
		DM_PLAIN = 3'd0,
		DM_ESC   = 3'd1,
		DM_HEX   = 3'd2,
		DM_OCT   = 3'd3
	} dec_mode_e;

	// Predicts decoded bytes per input transaction and checks result transactions
	class esd_scoreboard;
		dec_mode_e  mode;
		logic [7:0] acc;
		logic [1:0] ndig;
		logic [7:0] letter;
		logic [7:0] produced[$];
		esd_out_t   decoded_q[$];
		int         errors;
		int         inputs;
		int         checked;

		function new();
			clear_escape();
			errors = 0;
			inputs = 0;
			checked = 0;
		endfunction

		function void clear_escape();
			mode = DM_PLAIN;
			acc = 8'h00;
			ndig = 2'd0;
			letter = 8'h00;
		endfunction

		// At most three bytes come out of one transaction
		function void emit(logic [7:0] b);
			if (produced.size() < MaxResults)
				produced.push_back(b);
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE)
				return int'(c - CH_ZERO);
			if (c >= CH_LC_A && c <= CH_LC_F)
				return int'(c - CH_LC_A) + 10;
			if (c >= CH_UC_A && c <= CH_UC_F)
				return int'(c - CH_UC_A) + 10;
			return -1;
		endfunction

		function bit is_oct(logic [7:0] c);
			return (c >= CH_ZERO && c <= CH_SEVEN);
		endfunction

		// Emit what a pending escape stands for and go back to plain text
		function void flush_escape();
			case (mode)
				DM_ESC: emit(CH_BSLASH);
				DM_HEX: begin
					if (ndig == 2'd0) begin
						emit(CH_BSLASH);
						emit(letter);
					end else begin
						emit(acc);
					end
				end
				DM_OCT: emit(acc);
				default: ;
			endcase
			clear_escape();
		endfunction

		function void take_plain(logic [7:0] c);
			if (c == CH_BSLASH) begin
				mode = DM_ESC;
				acc = 8'h00;
				ndig = 2'd0;
			end else begin
				emit(c);
			end
		endfunction

		function void note_input(esd_in_t it);
			logic [7:0] c;
			int         d;
			esd_out_t   r;
			c = it.in_byte;
			produced.delete();
			inputs++;
			case (mode)
				DM_ESC: begin
					case (c)
						CH_LC_N: begin emit(CODE_LF); clear_escape(); end
						CH_LC_R: begin emit(CODE_CR); clear_escape(); end
						CH_LC_T: begin emit(CODE_HT); clear_escape(); end
						CH_LC_B: begin emit(CODE_VT); clear_escape(); end
						CH_LC_F: begin emit(CODE_FF); clear_escape(); end
						CH_BSLASH, CH_DOLLAR, CH_DQUOTE: begin
							emit(c);
							clear_escape();
						end
						CH_LC_X, CH_UC_X: begin
							mode = DM_HEX;
							letter = c;
							acc = 8'h00;
							ndig = 2'd0;
						end
						default: begin
							if (is_oct(c)) begin
								mode = DM_OCT;
								acc = c - CH_ZERO;
								ndig = 2'd1;
							end else begin
								// unknown escape: both characters pass literally
								emit(CH_BSLASH);
								emit(c);
								clear_escape();
							end
						end
					endcase
				end
				DM_HEX: begin
					d = nibble_of(c);
					if (d >= 0) begin
						acc = {acc[3:0], d[3:0]};
						ndig = ndig + 2'd1;
						if (ndig >= 2'd2) begin
							emit(acc);
							clear_escape();
						end
					end else begin
						flush_escape();
						take_plain(c);
					end
				end
				DM_OCT: begin
					if (is_oct(c)) begin
						acc = {acc[4:0], c[2:0]};
						ndig = ndig + 2'd1;
						if (ndig >= 2'd3) begin
							emit(acc);
							clear_escape();
						end
					end else begin
						flush_escape();
						take_plain(c);
					end
				end
				default: begin
					mode = DM_PLAIN;
					take_plain(c);
				end
			endcase
			// Last character flushes any pending escape
			if (it.in_last)
				flush_escape();
			foreach (produced[i]) begin
				r.out_byte = produced[i];
				r.out_last = it.in_last && (i == produced.size() - 1);
				decoded_q.push_back(r);
			end
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(esd_out_t got);
			esd_out_t want;
			checked++;
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte=%02h last=%0b",
					got.out_byte, got.out_last));
			end else begin
				want = decoded_q.pop_front();
				if (got.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, predicted %02h",
						got.out_byte, want.out_byte));
				if (got.out_last !== want.out_last)
					report_mismatch($sformatf("out_last %0b, predicted %0b (byte %02h)",
						got.out_last, want.out_last, want.out_byte));
			end
		endtask

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	esd_in_t  in_item;
	logic     out_valid;
	logic     out_stall;
	esd_out_t out_item;

	esd_scoreboard sb = new();

	int         idle_pct;
	int         stall_pct;
	bit         hold_req;
	int         hold_left;
	logic [7:0] str_q[$];

	escape_sequence_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#2_000_000;
		$display("timeout: %0d transactions still predicted", sb.pending());
		$display("testbench: done, errors");
		$finish;
	end

	// Result side: random stall, long hold on request, check each transaction
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(0, 99) < stall_pct);
			end
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(out_item);
		end
	end

	// Offer one character; return at the falling edge after it is taken
	task send_byte(logic [7:0] b, logic l);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item.in_byte = b;
		in_item.in_last = l;
		do @(posedge clk); while (in_stall);
		sb.note_input(in_item);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Send a whole string, last set on its final character
	task send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task send_queue();
		foreach (str_q[i])
			send_byte(str_q[i], i == str_q.size() - 1);
	endtask

	task wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
	endfunction

	// Build a random string of mostly well-formed escapes with random content
	function void build_string();
		logic [7:0] simple[8];
		logic [7:0] b;
		int         nseg;
		int         nd;
		simple = '{CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_B, CH_LC_F,
			CH_BSLASH, CH_DOLLAR, CH_DQUOTE};
		str_q.delete();
		nseg = $urandom_range(1, 7);
		for (int s = 0; s < nseg; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// ordinary character
					do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
					str_q.push_back(b);
				end
				3, 4: begin
					str_q.push_back(CH_BSLASH);
					str_q.push_back(simple[$urandom_range(0, 7)]);
				end
				5, 6: begin
					// hex escape with zero to two digits
					str_q.push_back(CH_BSLASH);
					str_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
					nd = $urandom_range(0, 2);
					for (int k = 0; k < nd; k++)
						str_q.push_back(rand_hex_char());
				end
				7, 8: begin
					// octal escape with one to three digits
					str_q.push_back(CH_BSLASH);
					nd = $urandom_range(1, 3);
					for (int k = 0; k < nd; k++)
						str_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
				end
				default: begin
					// noise: escape with any byte, or a bare random byte
					if ($urandom_range(0, 1))
						str_q.push_back(CH_BSLASH);
					str_q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endfunction

	// Stimulus
	initial begin
		int idle_tab[4];
		int stall_tab[4];
		int phase_start;
		bit held;
		idle_tab = '{0, 49, 0, 34};
		stall_tab = '{0, 0, 49, 34};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		hold_req = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: byte extremes, zero byte opening a string, each escape kind and flush
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_str("\\n");
		send_str("\\x41");
		send_str("\\101");
		send_str("\\8");
		send_str("\\xg");
		send_str("\\7z");
		send_str("\\X4");
		send_str("\\");
		send_str("\\x");
		wait_drained();

		// Random strings over four idle/stall mixes
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			phase_start = sb.inputs;
			held = 1'b0;
			while (sb.inputs - phase_start < 72) begin
				// long result-side hold while input keeps coming
				if (!held && sb.inputs - phase_start > 20) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
				build_string();
				send_queue();
			end
			// hold input until every predicted byte is out
			in_valid = 1'b0;
			wait_drained();
		end

		in_valid = 1'b0;
		wait_drained();
		repeat (20) @(negedge clk);
		$display("summary: %0d input transactions, %0d results checked", sb.inputs,
			sb.checked);
		$display("summary: escapes of every kind, flushes at end of string, four stall mixes");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/esd_pkg.sv
src/esd_decode.sv
src/esd_outq.sv
src/escape_sequence_decoder.sv
src/esd_checker.sv
tb/testbench.sv
